// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// holds on every clock edge outside reset
`define DHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on every clock edge outside reset
`define DHQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define DHQ_ASSERT(label, prop, msg)
`define DHQ_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

// ----- hdl/dhq_pkg.sv -----
// ----------------------------------------------------------------------------
// dhq_pkg
// shared constants and types of the d-ary heap priority queue
// ----------------------------------------------------------------------------
package dhq_pkg;

  localparam int ITEMS_DEF = 1024;
  localparam int ARITY_DEF = 4;

  localparam int ITEM_W = 10;
  localparam int KEY_W  = 31;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 11;

  // opcodes
  localparam logic [1:0] OP_RELAX   = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] RES_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] RES_DECREASED = 3'd1;
  localparam logic [STAT_W-1:0] RES_IGNORED   = 3'd2;
  localparam logic [STAT_W-1:0] RES_EXTRACTED = 3'd3;
  localparam logic [STAT_W-1:0] RES_EMPTY     = 3'd4;
  localparam logic [STAT_W-1:0] RES_CLEARED   = 3'd5;

  // per-item status
  localparam logic [1:0] ST_UNSEEN = 2'd0;
  localparam logic [1:0] ST_QUEUED = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic [KEY_W-1:0]  key;
  } heap_ent_t;

endpackage

// ----- hdl/dhq_ram.sv -----
// ----------------------------------------------------------------------------
// dhq_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module dhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dary_heap_dijkstra_queue_top.sv -----
// ----------------------------------------------------------------------------
// dary_heap_dijkstra_queue_top
// d-ary min-heap with decrease-key, item status and slot map in two memories
// ----------------------------------------------------------------------------
// relax: map read, key check if queued, then parent read and compare per level;
//   extract: root and last entry reads, then child reads and compare per level
// throughput: one request at a time, set by the single heap memory read port
// clear: a sweep of the status memory, then a cleared result
// reset: synchronous, then a status memory sweep with in_stall high
// ----------------------------------------------------------------------------
module dary_heap_dijkstra_queue_top #(
  parameter int ITEMS = dhq_pkg::ITEMS_DEF,
  parameter int ARITY = dhq_pkg::ARITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [dhq_pkg::ITEM_W-1:0] in_item,
  input  logic [dhq_pkg::KEY_W-1:0]  in_distance,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dhq_pkg::STAT_W-1:0] out_status,
  output logic [dhq_pkg::ITEM_W-1:0] out_item,
  output logic [dhq_pkg::KEY_W-1:0]  out_distance,
  output logic [dhq_pkg::CNT_W-1:0]  out_queue_count
);
  import dhq_pkg::*;
  `include "assert_macros.svh"

  localparam int SW  = $clog2(ITEMS);
  localparam int SZW = $clog2(ITEMS + 1);
  localparam int KW  = (ARITY > 2) ? $clog2(ARITY) : 1;
  localparam int CW  = SW + $clog2(ARITY) + 1;
  localparam int HW  = ITEM_W + KEY_W;
  localparam int MW  = SW + 2;

  typedef enum logic [11:0] {
    S_CLR     = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_RLX_RD  = 12'b000000000100,
    S_RLX_CHK = 12'b000000001000,
    S_UP      = 12'b000000010000,
    S_UP_CMP  = 12'b000000100000,
    S_EX_RD   = 12'b000001000000,
    S_EX_LAST = 12'b000010000000,
    S_DN      = 12'b000100000000,
    S_DN_RD   = 12'b001000000000,
    S_DN_CMP  = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ITEM_W-1:0] item_r, item_nxt;
  logic [KEY_W-1:0]  dist_r, dist_nxt;
  logic [SZW-1:0]    size_r, size_nxt;
  logic [SW-1:0]     pos_r, pos_nxt;
  heap_ent_t         held_r, held_nxt;
  heap_ent_t         best_r, best_nxt;
  logic [SW-1:0]     bslot_r, bslot_nxt;
  logic [SW-1:0]     cidx_r, cidx_nxt;
  logic [KW-1:0]     kcnt_r, kcnt_nxt;
  logic [SW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              clr_resp_r, clr_resp_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic [ITEM_W-1:0] res_oi_r, res_oi_nxt;
  logic [KEY_W-1:0]  res_od_r, res_od_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [ITEM_W-1:0] out_item_r;
  logic [KEY_W-1:0]  out_distance_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              load_out;

  // heap memory and item map memory ports
  logic          hw_en;
  logic [SW-1:0] hw_addr, hr_addr;
  heap_ent_t     hw_data, hq;
  logic [HW-1:0] hq_raw;
  logic          sw_en;
  logic [SW-1:0] sw_addr, sr_addr;
  logic [MW-1:0] sw_data, sq;
  logic [1:0]    sq_st;
  logic [SW-1:0] sq_slot;

  logic [CW-1:0]  first_w;
  logic [SW-1:0]  parent_w;
  logic [SZW-1:0] next_c;
  logic           accept;

  dhq_ram #(.WIDTH(HW), .DEPTH(ITEMS)) u_heap_ram (
    .clk   (clk),
    .we    (hw_en),
    .waddr (hw_addr),
    .wdata (hw_data),
    .raddr (hr_addr),
    .rdata (hq_raw)
  );

  dhq_ram #(.WIDTH(MW), .DEPTH(ITEMS)) u_map_ram (
    .clk   (clk),
    .we    (sw_en),
    .waddr (sw_addr),
    .wdata (sw_data),
    .raddr (sr_addr),
    .rdata (sq)
  );

  assign hq      = hq_raw;
  assign sq_st   = sq[SW+1:SW];
  assign sq_slot = sq[SW-1:0];

  assign first_w  = CW'(pos_r) * CW'(ARITY) + CW'(1);
  assign parent_w = SW'((CW'(pos_r) - CW'(1)) / CW'(ARITY));
  assign next_c   = SZW'(cidx_r) + SZW'(1);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign load_out = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    dist_nxt     = dist_r;
    size_nxt     = size_r;
    pos_nxt      = pos_r;
    held_nxt     = held_r;
    best_nxt     = best_r;
    bslot_nxt    = bslot_r;
    cidx_nxt     = cidx_r;
    kcnt_nxt     = kcnt_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_resp_nxt = clr_resp_r;
    res_st_nxt   = res_st_r;
    res_oi_nxt   = res_oi_r;
    res_od_nxt   = res_od_r;
    hw_en        = 1'b0;
    hw_addr      = pos_r;
    hw_data      = held_r;
    hr_addr      = '0;
    sw_en        = 1'b0;
    sw_addr      = SW'(held_r.item);
    sw_data      = {ST_QUEUED, pos_r};
    sr_addr      = SW'(in_item);

    case (state_r)
      S_CLR: begin
        sw_en       = 1'b1;
        sw_addr     = clr_cnt_r;
        sw_data     = '0;
        clr_cnt_nxt = clr_cnt_r + SW'(1);
        if (clr_cnt_r == SW'(ITEMS - 1)) begin
          clr_cnt_nxt = '0;
          if (clr_resp_r) begin
            res_st_nxt = RES_CLEARED;
            res_oi_nxt = '0;
            res_od_nxt = '0;
            state_nxt  = S_RESP;
          end else begin
            state_nxt  = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt   = in_item;
          dist_nxt   = in_distance;
          res_st_nxt = RES_IGNORED;
          res_oi_nxt = '0;
          res_od_nxt = '0;
          case (in_opcode)
            OP_RELAX: begin
              res_oi_nxt = in_item;
              if (32'(in_item) < 32'(ITEMS)) begin
                state_nxt = S_RLX_RD;
              end else begin
                state_nxt = S_RESP;
              end
            end
            OP_EXTRACT: begin
              hr_addr = '0;
              if (size_r == '0) begin
                res_st_nxt = RES_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt  = S_EX_RD;
              end
            end
            OP_CLEAR: begin
              size_nxt     = '0;
              clr_cnt_nxt  = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_RLX_RD: begin
        hr_addr = sq_slot;
        if (sq_st == ST_UNSEEN && size_r < SZW'(ITEMS)) begin
          pos_nxt    = SW'(size_r);
          size_nxt   = size_r + SZW'(1);
          held_nxt   = '{item: item_r, key: dist_r};
          res_st_nxt = RES_INSERTED;
          res_od_nxt = dist_r;
          state_nxt  = S_UP;
        end else if (sq_st == ST_QUEUED && SZW'(sq_slot) < size_r) begin
          pos_nxt    = sq_slot;
          state_nxt  = S_RLX_CHK;
        end else begin
          state_nxt  = S_RESP;
        end
      end
      S_RLX_CHK: begin
        if (hq.item == item_r) begin
          if (dist_r < hq.key) begin
            held_nxt   = '{item: item_r, key: dist_r};
            res_st_nxt = RES_DECREASED;
            res_od_nxt = dist_r;
            state_nxt  = S_UP;
          end else begin
            res_od_nxt = hq.key;
            state_nxt  = S_RESP;
          end
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_UP: begin
        hr_addr = parent_w;
        if (pos_r == '0) begin
          hw_en     = 1'b1;
          sw_en     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        hw_en = 1'b1;
        sw_en = 1'b1;
        if (held_r.key < hq.key) begin
          // parent moves down into the hole
          hw_data   = hq;
          sw_addr   = SW'(hq.item);
          pos_nxt   = parent_w;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_EX_RD: begin
        res_st_nxt = RES_EXTRACTED;
        res_oi_nxt = hq.item;
        res_od_nxt = hq.key;
        size_nxt   = size_r - SZW'(1);
        sw_en      = 1'b1;
        sw_addr    = SW'(hq.item);
        sw_data    = {ST_DONE, {SW{1'b0}}};
        hr_addr    = SW'(size_r - SZW'(1));
        if (size_r > SZW'(1)) begin
          state_nxt = S_EX_LAST;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_EX_LAST: begin
        held_nxt  = hq;
        pos_nxt   = '0;
        state_nxt = S_DN;
      end
      S_DN: begin
        hr_addr = SW'(first_w);
        if (first_w >= CW'(size_r)) begin
          hw_en     = 1'b1;
          sw_en     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cidx_nxt  = SW'(first_w);
          kcnt_nxt  = '0;
          state_nxt = S_DN_RD;
        end
      end
      S_DN_RD: begin
        // first smallest child wins, later ones only on strictly less
        if (kcnt_r == '0 || hq.key < best_r.key) begin
          best_nxt  = hq;
          bslot_nxt = cidx_r;
        end
        hr_addr = SW'(next_c);
        if ((32'(kcnt_r) + 1) < ARITY && next_c < size_r) begin
          cidx_nxt = SW'(next_c);
          kcnt_nxt = kcnt_r + KW'(1);
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        hw_en = 1'b1;
        sw_en = 1'b1;
        if (best_r.key < held_r.key) begin
          hw_data   = best_r;
          sw_addr   = SW'(best_r.item);
          pos_nxt   = bslot_r;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      size_r      <= '0;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    dist_r   <= dist_nxt;
    pos_r    <= pos_nxt;
    held_r   <= held_nxt;
    best_r   <= best_nxt;
    bslot_r  <= bslot_nxt;
    cidx_r   <= cidx_nxt;
    kcnt_r   <= kcnt_nxt;
    res_st_r <= res_st_nxt;
    res_oi_r <= res_oi_nxt;
    res_od_r <= res_od_nxt;
    if (load_out) begin
      out_status_r   <= res_st_r;
      out_item_r     <= res_oi_r;
      out_distance_r <= res_od_r;
      out_count_r    <= CNT_W'(size_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item        = out_item_r;
  assign out_distance    = out_distance_r;
  assign out_queue_count = out_count_r;

  `DHQ_ASSERT(a_size_bound, size_r <= SZW'(ITEMS), "heap size beyond capacity")
  `DHQ_ASSERT_IMP(a_out_from_resp, $rose(out_valid_r), $past(state_r == S_RESP), "result without response state")
  `DHQ_ASSERT_IMP(a_pos_live, state_r == S_UP || state_r == S_DN, SZW'(pos_r) < size_r, "sift position outside heap")
  `DHQ_ASSERT_IMP(a_heap_wr_live, hw_en, SZW'(hw_addr) < size_r, "heap write outside live slots")

endmodule

// ----- tb/heap_queue_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_queue_checker
// watches both channels of the heap queue, keeps its own 4-ary heap with
// decrease-key and compares every result against the predicted one
// ----------------------------------------------------------------------------
module heap_queue_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [dhq_pkg::ITEM_W-1:0] in_item,
  input  logic [dhq_pkg::KEY_W-1:0]  in_distance,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [dhq_pkg::STAT_W-1:0] out_status,
  input  logic [dhq_pkg::ITEM_W-1:0] out_item,
  input  logic [dhq_pkg::KEY_W-1:0]  out_distance,
  input  logic [dhq_pkg::CNT_W-1:0]  out_queue_count,
  output int                         fail_count,
  output int                         pending,
  output int                         n_results,
  output int                         n_extracted,
  output int                         n_decreased
);
  import dhq_pkg::*;

  localparam int N_ITEMS = ITEMS_DEF;
  localparam int N_ARITY = ARITY_DEF;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ITEM_W-1:0] item;
    logic [KEY_W-1:0]  dkey;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  heap_ent_t  pq_slot [N_ITEMS];
  int         pq_pos  [N_ITEMS];
  logic [1:0] pq_state[N_ITEMS];
  int         pq_size;
  outcome_t   awaited[$];

  initial begin
    fail_count = 0;
    pending = 0;
    n_results = 0;
    n_extracted = 0;
    n_decreased = 0;
    pq_size = 0;
    for (int i = 0; i < N_ITEMS; i++) pq_state[i] = ST_UNSEEN;
  end

  function automatic void swap_ent(int a, int b);
    heap_ent_t t;
    t = pq_slot[a];
    pq_slot[a] = pq_slot[b];
    pq_slot[b] = t;
    pq_pos[pq_slot[a].item] = a;
    pq_pos[pq_slot[b].item] = b;
  endfunction

  function automatic void bubble_up(int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / N_ARITY;
      if (!(pq_slot[s].key < pq_slot[p].key)) break;
      swap_ent(s, p);
      s = p;
    end
  endfunction

  function automatic void bubble_down(int s);
    int first, best;
    forever begin
      first = s * N_ARITY + 1;
      if (first >= pq_size) break;
      best = first;
      for (int i = 1; i < N_ARITY; i++) begin
        if (first + i >= pq_size) break;
        if (pq_slot[first + i].key < pq_slot[best].key) best = first + i;
      end
      if (!(pq_slot[best].key < pq_slot[s].key)) break;
      swap_ent(s, best);
      s = best;
    end
  endfunction

  function automatic outcome_t apply_request(logic [1:0] op, logic [ITEM_W-1:0] it,
                                             logic [KEY_W-1:0] d);
    outcome_t r;
    int s;
    r = '0;
    r.status = RES_IGNORED;
    if (op == OP_RELAX) begin
      r.item = it;
      if (pq_state[it] == ST_UNSEEN && pq_size < N_ITEMS) begin
        s = pq_size;
        pq_size++;
        pq_slot[s].item = it;
        pq_slot[s].key = d;
        pq_pos[it] = s;
        pq_state[it] = ST_QUEUED;
        bubble_up(s);
        r.status = RES_INSERTED;
        r.dkey = d;
      end else if (pq_state[it] == ST_QUEUED) begin
        s = pq_pos[it];
        if (d < pq_slot[s].key) begin
          pq_slot[s].key = d;
          bubble_up(s);
          r.status = RES_DECREASED;
          r.dkey = d;
        end else begin
          r.dkey = pq_slot[s].key;
        end
      end
    end else if (op == OP_EXTRACT) begin
      if (pq_size == 0) begin
        r.status = RES_EMPTY;
      end else begin
        r.status = RES_EXTRACTED;
        r.item = pq_slot[0].item;
        r.dkey = pq_slot[0].key;
        pq_size--;
        pq_state[pq_slot[0].item] = ST_DONE;
        if (pq_size > 0) begin
          pq_slot[0] = pq_slot[pq_size];
          pq_pos[pq_slot[0].item] = 0;
          bubble_down(0);
        end
      end
    end else if (op == OP_CLEAR) begin
      for (int i = 0; i < N_ITEMS; i++) pq_state[i] = ST_UNSEEN;
      pq_size = 0;
      r.status = RES_CLEARED;
    end
    r.count = CNT_W'(pq_size);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && in_valid && !in_stall)
      awaited.insert(awaited.size(), apply_request(in_opcode, in_item, in_distance));
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, -1);
      end else begin
        w = awaited.pop_front();
        if (out_status == RES_EXTRACTED) n_extracted++;
        if (out_status == RES_DECREASED) n_decreased++;
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_item !== w.item) report_mismatch("item", out_item, w.item);
        if (out_distance !== w.dkey) report_mismatch("distance", out_distance, w.dkey);
        if (out_queue_count !== w.count)
          report_mismatch("queue count", out_queue_count, w.count);
      end
    end
    pending = awaited.size();
  end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives relax, extract, clear and no-op requests into the heap queue with
// random gaps and output stalls; checking is done by heap_queue_checker
// ----------------------------------------------------------------------------
module testbench;
  import dhq_pkg::*;

  localparam int STUCK_LIMIT = 20000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_opcode;
  logic [ITEM_W-1:0] in_item;
  logic [KEY_W-1:0]  in_distance;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] out_status;
  logic [ITEM_W-1:0] out_item;
  logic [KEY_W-1:0]  out_distance;
  logic [CNT_W-1:0]  out_queue_count;
  int fail_count, pending, n_results, n_extracted, n_decreased;
  int idle_cycles, n_sent;
  bit quiet_phase;

  dary_heap_dijkstra_queue_top dut (.*);

  heap_queue_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls about 17 in 100, except during the quiet stretch
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !quiet_phase && ($urandom_range(99) < 17);
    end
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [ITEM_W-1:0] it, logic [KEY_W-1:0] d);
    while (!quiet_phase && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_item <= it;
    in_distance <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic [KEY_W-1:0] rand_dist();
    case ($urandom_range(3))
      0: return KEY_W'($urandom_range(15));
      1: return KEY_W'({$urandom} >> 1);
      2: return KEY_W'(2147483647 - $urandom_range(3));
      default: return KEY_W'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    logic [ITEM_W-1:0] base;
    int len;
    idle_cycles = 0;
    n_sent = 0;
    quiet_phase = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_RELAX;
    in_item = '0;
    in_distance = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty extract, extremes, decrease, ignore, done item, clear, no-op
    send(OP_EXTRACT, '0, '0);
    send(OP_RELAX, 10'd0, 31'h7fffffff);
    send(OP_RELAX, 10'd1023, 31'd0);
    send(OP_RELAX, 10'd5, 31'd100);
    send(OP_RELAX, 10'd6, 31'd100);
    send(OP_RELAX, 10'd5, 31'd100);
    send(OP_RELAX, 10'd5, 31'd200);
    send(OP_RELAX, 10'd0, 31'd50);
    send(OP_RELAX, 10'd6, 31'd0);
    send(OP_EXTRACT, 10'h3ff, 31'h7fffffff);
    send(OP_EXTRACT, '0, '0);
    send(OP_RELAX, 10'd1023, 31'd7);
    send(OP_NOP, 10'h2aa, 31'h2aaaaaaa);
    repeat (4) send(OP_EXTRACT, '0, '0);
    send(OP_CLEAR, 10'h155, 31'h55555555);
    send(OP_RELAX, 10'd1023, 31'd3);
    send(OP_EXTRACT, '0, '0);
    send(OP_CLEAR, '0, '0);

    // random: mostly Dijkstra-like bursts of relaxes then extracts
    while (n_sent < 540) begin
      quiet_phase = (n_sent > 300 && n_sent < 380);
      len = $urandom_range(1, 12);
      base = ITEM_W'($urandom);
      case ($urandom_range(9))
        0: send(OP_CLEAR, ITEM_W'($urandom), KEY_W'($urandom));
        1: send(OP_NOP, ITEM_W'($urandom), KEY_W'($urandom));
        2, 3: repeat (len) send(OP_EXTRACT, ITEM_W'($urandom), KEY_W'($urandom));
        default: begin
          repeat (len) send(OP_RELAX, base + ITEM_W'($urandom_range(15)), rand_dist());
          repeat ($urandom_range(len)) send(OP_EXTRACT, '0, '0);
        end
      endcase
    end
    in_valid <= 1'b0;
    quiet_phase = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d requests, %0d results checked", n_sent, n_results);
    $display("%0d extractions and %0d key decreases seen", n_extracted, n_decreased);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/dhq_pkg.sv
hdl/dhq_ram.sv
hdl/dary_heap_dijkstra_queue_top.sv
tb/heap_queue_checker.sv
tb/testbench.sv
